FILE: rtl/pspit_pkg.sv
package pspit_pkg;

  // Fixed port widths of the item and result fields
  localparam int SRC_W = 4;
  localparam int ID_W  = 32;

  // Depth of the queue between accept side and state update side
  localparam int QDEPTH = 2;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_RECORD = 1'b1
  } op_e;

  // Classified item as it travels through the queue
  typedef struct packed {
    op_e              op;
    logic             in_range;
    logic [SRC_W-1:0] source;
    logic [ID_W-1:0]  packet_id;
  } item_t;

  typedef struct packed {
    logic            seen;
    logic            ord;
    logic            ovf;
    logic [ID_W-1:0] next;
  } result_t;

endpackage

FILE: rtl/pspit_front.sv
module pspit_front #(
  parameter int NODES = 16
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [pspit_pkg::SRC_W-1:0]  source_i,
  input  logic [pspit_pkg::ID_W-1:0]   packet_id_i,
  input  logic                         q_ready_i,
  input  logic                         clr_busy_i,
  output logic                         push_o,
  output pspit_pkg::item_t             item_o
);
  import pspit_pkg::*;

  // no intake while the state store is being swept clear
  assign in_ready_o = q_ready_i && !clr_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    item_o           = '0;
    item_o.op        = op_i ? OP_RECORD : OP_CHECK;
    item_o.in_range  = (32'(source_i) < 32'(NODES));
    item_o.source    = source_i;
    item_o.packet_id = packet_id_i;
  end

endmodule

FILE: rtl/pspit_queue.sv
module pspit_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pspit_pkg::item_t  item_i,
  output logic              ready_o,
  output logic              valid_o,
  output pspit_pkg::item_t  item_o,
  input  logic              pop_i
);
  import pspit_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/pspit_back.sv
module pspit_back #(
  parameter int NODES   = 16,
  parameter int WINDOW  = 64,
  parameter int ID_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  pspit_pkg::item_t            q_item_i,
  output logic                        pop_o,
  output logic                        clr_busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pspit_pkg::result_t          res_o
);
  import pspit_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int EW    = ID_BITS + WINDOW;
  localparam int WB    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_EVAL,
    S_ADV
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   clr_q;
  logic               out_valid_q;
  result_t            out_q;
  item_t              item_q;
  logic [CW-1:0]      tz_q;
  logic [EW-1:0]      rd_q;
  logic [EW-1:0]      mem [NODES];

  logic               out_free;
  logic [IDX_W-1:0]   rd_idx, wr_idx, mem_waddr;
  logic               mem_we;
  logic [EW-1:0]      mem_wdata;
  logic               res_fire, go_adv;
  result_t            res_d;

  logic [ID_BITS-1:0] id, cur_next, id_ofs, adv_next;
  logic [WINDOW-1:0]  cur_map, adv_map, set_bit;
  logic               below, eq, gt, in_win, seen;
  logic [CW-1:0]      ones_cnt;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign clr_busy_o  = (state_q == S_CLR);
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign rd_idx = IDX_W'(q_item_i.source);
  assign wr_idx = IDX_W'(item_q.source);

  // current per-source state as read back from the store
  assign cur_next = rd_q[EW-1:WINDOW];
  assign cur_map  = rd_q[WINDOW-1:0];
  assign id       = ID_BITS'(item_q.packet_id);

  assign below   = (id < cur_next);
  assign eq      = (id == cur_next);
  assign gt      = !below && !eq;
  assign id_ofs  = id - cur_next - ID_BITS'(1);
  assign in_win  = gt && (64'(id_ofs) < 64'(WINDOW));
  assign seen    = below || (in_win && cur_map[id_ofs[WB-1:0]]);
  assign set_bit = WINDOW'(1) << id_ofs[WB-1:0];

  // run of consecutive early ids just past the expected one
  always_comb begin
    ones_cnt = CW'(WINDOW);
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!cur_map[i]) begin
        ones_cnt = CW'(i);
      end
    end
  end

  assign adv_next = cur_next + ID_BITS'(tz_q) + ID_BITS'(1);
  assign adv_map  = (cur_map >> tz_q) >> 1;

  always_comb begin
    res_fire  = 1'b0;
    go_adv    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = '0;
    res_d     = '0;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_EVAL: begin
        if (!item_q.in_range) begin
          res_fire = out_free;
        end else if (item_q.op == OP_CHECK || seen) begin
          res_d.seen = seen;
          res_d.next = ID_W'(cur_next);
          res_fire   = out_free;
        end else if (eq) begin
          go_adv = 1'b1;
        end else if (in_win) begin
          res_d.next = ID_W'(cur_next);
          res_fire   = out_free;
          mem_we     = out_free;
          mem_wdata  = {cur_next, cur_map | set_bit};
        end else begin
          res_d.ovf  = 1'b1;
          res_d.next = ID_W'(cur_next);
          res_fire   = out_free;
        end
      end
      S_ADV: begin
        res_d.ord  = 1'b1;
        res_d.next = ID_W'(adv_next);
        res_fire   = out_free;
        mem_we     = out_free;
        mem_wdata  = {adv_next, adv_map};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(NODES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (go_adv) begin
            state_q <= S_ADV;
          end else if (res_fire) begin
            state_q <= S_IDLE;
          end
        end
        S_ADV: begin
          if (res_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_q <= res_d;
    end
    if (pop_o) begin
      item_q <= q_item_i;
    end
    if (go_adv) begin
      tz_q <= ones_cnt;
    end
  end

  // per-source state store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_q <= mem[rd_idx];
    end
  end

endmodule

FILE: rtl/per_source_packet_id_tracker_unit.sv
// Per-source packet id tracker. Each transfer on the input channel names a
// source, a packet id and an op: check reports whether that id was already
// received, record marks it. Per source the unit keeps the next expected id
// and a WINDOW-bit map of ids that arrived early (bit k stands for id
// next + 1 + k). Recording the expected id moves it past the whole run of
// already marked ids and shifts the map along; an early id inside the window
// sets its bit; one beyond the window is dropped and flagged in
// window_overflow; an id below the expected one changes nothing. A source
// index of NODES or more yields an all-zero result. Exactly one result
// transfer follows each input transfer, in order.
// After reset the state store is swept clear entry by entry, during which
// in_ready_o is low. Afterwards the update engine takes one item at a time:
// store read, then evaluate and write back, or, when a recorded id is the
// expected one, run count, then advance and write back. The per-source
// store has one write port and one registered read port; a 2-entry queue
// and the output register keep intake and delivery running while the
// engine or the consumer stalls.
module per_source_packet_id_tracker_unit #(
  parameter int NODES   = 16,
  parameter int WINDOW  = 64,
  parameter int ID_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [pspit_pkg::SRC_W-1:0] source_i,
  input  logic [pspit_pkg::ID_W-1:0]  packet_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        already_received_o,
  output logic                        in_order_o,
  output logic                        window_overflow_o,
  output logic [pspit_pkg::ID_W-1:0]  next_expected_o
);
  import pspit_pkg::*;

  item_t   push_item, head_item;
  logic    push, q_ready, q_valid, pop, clr_busy;
  result_t res;

  // intake: handshake and source range classification
  pspit_front #(
    .NODES (NODES)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .source_i    (source_i),
    .packet_id_i (packet_id_i),
    .q_ready_i   (q_ready),
    .clr_busy_i  (clr_busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decouples intake from the state update engine
  pspit_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  // state store, read-modify-write engine and output register
  pspit_back #(
    .NODES   (NODES),
    .WINDOW  (WINDOW),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign already_received_o = res.seen;
  assign in_order_o         = res.ord;
  assign window_overflow_o  = res.ovf;
  assign next_expected_o    = res.next;

endmodule
